[hw/rtl/tkd_pkg.sv]
// Package for the terminal key sequence decoder.
// Holds request codes, parse phases, key codes and the key event record.
// Has no dependencies; the decoder top level uses it by scoped names.
`default_nettype none

package tkd_pkg;

  // Request codes on the input channel
  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_TICK = 2'd1,
    REQ_EOS  = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // Parse phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_CSI     = 3'd2,
    PH_NUM     = 3'd3,
    PH_MODWAIT = 3'd4,
    PH_MODKEY  = 3'd5,
    PH_SS3     = 3'd6
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_ESC_WAIT = 2'd0;
  localparam logic [1:0] CFG_SEQ_WAIT = 2'd1;

  localparam logic [15:0] ESC_WAIT_RST = 16'd100;
  localparam logic [15:0] SEQ_WAIT_RST = 16'd50;

  // Key codes above the raw byte range, and K_NONE for no key
  localparam logic [8:0] K_UP        = 9'd256;
  localparam logic [8:0] K_DOWN      = 9'd257;
  localparam logic [8:0] K_LEFT      = 9'd258;
  localparam logic [8:0] K_RIGHT     = 9'd259;
  localparam logic [8:0] K_HOME      = 9'd260;
  localparam logic [8:0] K_END       = 9'd261;
  localparam logic [8:0] K_PGUP      = 9'd262;
  localparam logic [8:0] K_PGDN      = 9'd263;
  localparam logic [8:0] K_DELETE    = 9'd264;
  localparam logic [8:0] K_F2        = 9'd265;
  localparam logic [8:0] K_F5        = 9'd266;
  localparam logic [8:0] K_ENTER     = 9'd267;
  localparam logic [8:0] K_ESC       = 9'd268;
  localparam logic [8:0] K_BACKSPACE = 9'd269;
  localparam logic [8:0] K_TAB       = 9'd270;
  localparam logic [8:0] K_NONE      = 9'd0;

  // Special bytes
  localparam logic [7:0] B_CTRL_D = 8'd4;
  localparam logic [7:0] B_CTRL_Q = 8'd17;
  localparam logic [7:0] B_ESC    = 8'd27;
  localparam logic [7:0] B_CR     = 8'd13;
  localparam logic [7:0] B_LF     = 8'd10;
  localparam logic [7:0] B_TAB    = 8'd9;
  localparam logic [7:0] B_DEL    = 8'd127;
  localparam logic [7:0] B_QUIT   = 8'd113;  // 'q'
  localparam logic [7:0] B_LBRACK = 8'h5B;   // '['
  localparam logic [7:0] B_SS3    = 8'h4F;   // 'O'
  localparam logic [7:0] B_SEMI   = 8'h3B;   // ';'
  localparam logic [7:0] B_TILDE  = 8'h7E;   // '~'
  localparam logic [7:0] B_ZERO   = 8'h30;   // '0'
  localparam logic [7:0] B_BACKTAB = 8'h5A;  // 'Z'
  localparam logic [7:0] B_CASE_OFS = 8'd96; // Ctrl byte to lowercase letter

  // Modifier flag bits
  localparam logic [2:0] MF_NONE  = 3'b000;
  localparam logic [2:0] MF_CTRL  = 3'b001;
  localparam logic [2:0] MF_SHIFT = 3'b010;
  localparam logic [2:0] MF_ALT   = 3'b100;

  // Output queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // One key event as it waits for the result channel
  typedef struct packed {
    logic [8:0] key;
    logic [7:0] ch;
    logic [2:0] mods;
    logic       quit;
    logic       last;
  } event_t;

  // Build an event with no quit and no last mark
  function automatic event_t mk_event(input logic [8:0] key, input logic [7:0] ch,
                                      input logic [2:0] mods);
    event_t e;
    e.key  = key;
    e.ch   = ch;
    e.mods = mods;
    e.quit = 1'b0;
    e.last = 1'b0;
    return e;
  endfunction

  function automatic event_t quit_event();
    event_t e;
    e      = mk_event({1'b0, B_QUIT}, B_QUIT, MF_CTRL);
    e.quit = 1'b1;
    return e;
  endfunction

  // Arrow, home and end letters; zero when the letter means nothing
  function automatic logic [8:0] letter_key(input logic [7:0] c);
    logic [8:0] k;
    case (c)
      8'h41:   k = K_UP;
      8'h42:   k = K_DOWN;
      8'h43:   k = K_RIGHT;
      8'h44:   k = K_LEFT;
      8'h48:   k = K_HOME;
      8'h46:   k = K_END;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // Numeric parameter before a tilde
  function automatic logic [8:0] tilde_key(input logic [7:0] n);
    logic [8:0] k;
    case (n)
      8'd1:         k = K_HOME;
      8'd3:         k = K_DELETE;
      8'd4:         k = K_END;
      8'd5:         k = K_PGUP;
      8'd6:         k = K_PGDN;
      8'd11, 8'd12: k = K_F2;
      8'd15:        k = K_F5;
      default:      k = K_NONE;
    endcase
    return k;
  endfunction

  // Final byte of an SS3 sequence
  function automatic logic [8:0] ss3_key(input logic [7:0] c);
    logic [8:0] k;
    case (c)
      8'h50, 8'h51: k = K_F2;
      8'h54:        k = K_F5;
      8'h48:        k = K_HOME;
      8'h46:        k = K_END;
      default:      k = {1'b0, c};
    endcase
    return k;
  endfunction

  // Modifier digit after the semicolon
  function automatic logic [2:0] mod_flags(input logic [7:0] c);
    logic [2:0] m;
    case (c)
      8'h35:   m = MF_CTRL;
      8'h32:   m = MF_SHIFT;
      8'h33:   m = MF_ALT;
      8'h36:   m = MF_CTRL | MF_SHIFT;
      default: m = MF_NONE;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/terminal_key_sequence_decoder.sv]
// Terminal key sequence decoder: parse state, timeout counter and result queue.
// Depends on tkd_pkg for codes, key constants and the event record.
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready): one beat carries a request type and a byte:
//   a received terminal byte, a one millisecond tick or an end-of-stream mark.
//   Result channel (out_valid/out_ready): one beat per key event; out_last_of_run
//   marks the final event caused by an input beat. End of stream mid-sequence
//   yields two events (the resolved sequence, then the quit event).
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the Escape
//   wait, index 1 the per-byte sequence wait, both in ticks. Write only when idle.
// Timing
//   One input beat per cycle while in_ready is high. The parser updates in the
//   accept cycle and its events land in a four-entry result queue, so an event
//   is in the queue from the cycle after its input beat. in_ready is high while
//   the queue has room for two events; with the receiver always ready, the
//   block sustains one beat per cycle; an end-of-stream beat queues two events.
// Reset
//   Synchronous active-low rst_n empties the queue, returns the parser to idle and
//   loads the wait registers with 100 and 50 ticks.
// Stall
//   When out_ready stays low the queue fills and in_ready drops; nothing is lost.
module terminal_key_sequence_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_byte_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [8:0]       out_key_code,
  output logic [7:0]       out_char_value,
  output logic             out_ctrl_mod,
  output logic             out_shift_mod,
  output logic             out_alt_mod,
  output logic             out_quit_event,
  output logic             out_last_of_run,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers
  logic [15:0] esc_wait_r;
  logic [15:0] seq_wait_r;

  // Parser state
  tkd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      num_r, num_nxt;
  logic [2:0]      mods_r, mods_nxt;
  logic [15:0]     wait_cnt_r, wait_cnt_nxt;

  // Result queue
  tkd_pkg::event_t                 fifo_r [tkd_pkg::FIFO_DEPTH];
  logic [tkd_pkg::PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [tkd_pkg::CNT_W-1:0]       count_r, count_nxt;

  // Events produced by the beat being accepted
  tkd_pkg::event_t ev0, ev1;
  logic [1:0]      n_ev;

  logic            in_acc;
  logic            out_acc;
  logic [11:0]     num_prod;
  logic [16:0]     tick_next;
  logic [15:0]     wait_lim;
  tkd_pkg::event_t head;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count_r <= tkd_pkg::CNT_W'(tkd_pkg::FIFO_DEPTH - 2));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_acc   = out_valid && out_ready;

  // Write configuration; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_wait_r <= tkd_pkg::ESC_WAIT_RST;
      seq_wait_r <= tkd_pkg::SEQ_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tkd_pkg::CFG_ESC_WAIT: esc_wait_r <= cfg_data;
        tkd_pkg::CFG_SEQ_WAIT: seq_wait_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturating decimal accumulate, tick count and active wait limit
  assign num_prod  = {1'b0, num_r, 3'b000} + {3'b000, num_r, 1'b0}
                   + {4'b0000, in_byte_value - tkd_pkg::B_ZERO};
  assign tick_next = {1'b0, wait_cnt_r} + 17'd1;
  assign wait_lim  = (phase_r == tkd_pkg::PH_ESC) ? esc_wait_r : seq_wait_r;

  // Resolve the current phase as if its wait ran out
  function automatic tkd_pkg::event_t expire_event(input tkd_pkg::phase_t ph,
                                                   input logic [2:0] mods);
    tkd_pkg::event_t e;
    case (ph)
      tkd_pkg::PH_ESC, tkd_pkg::PH_CSI:
        e = tkd_pkg::mk_event(tkd_pkg::K_ESC, 8'd0, tkd_pkg::MF_NONE);
      tkd_pkg::PH_MODKEY:
        e = tkd_pkg::mk_event(tkd_pkg::K_NONE, 8'd0, mods);
      default:
        e = tkd_pkg::mk_event(tkd_pkg::K_NONE, 8'd0, tkd_pkg::MF_NONE);
    endcase
    return e;
  endfunction

  // Next parser state and the events of this beat
  always_comb begin
    phase_nxt    = phase_r;
    num_nxt      = num_r;
    mods_nxt     = mods_r;
    wait_cnt_nxt = wait_cnt_r;
    ev0          = '0;
    ev1          = '0;
    n_ev         = 2'd0;
    if (in_acc) begin
      case (in_req_type)
        tkd_pkg::REQ_BYTE: begin
          wait_cnt_nxt = '0;
          case (phase_r)
            tkd_pkg::PH_IDLE: begin
              n_ev = 2'd1;
              if (in_byte_value == tkd_pkg::B_CTRL_D || in_byte_value == tkd_pkg::B_CTRL_Q) begin
                ev0 = tkd_pkg::quit_event();
              end else if (in_byte_value == tkd_pkg::B_ESC) begin
                n_ev      = 2'd0;
                phase_nxt = tkd_pkg::PH_ESC;
              end else if (in_byte_value == tkd_pkg::B_CR || in_byte_value == tkd_pkg::B_LF) begin
                ev0 = tkd_pkg::mk_event(tkd_pkg::K_ENTER, tkd_pkg::B_CR, tkd_pkg::MF_NONE);
              end else if (in_byte_value == tkd_pkg::B_TAB) begin
                ev0 = tkd_pkg::mk_event(tkd_pkg::K_TAB, tkd_pkg::B_TAB, tkd_pkg::MF_NONE);
              end else if (in_byte_value inside {[8'd1:8'd26]}) begin
                ev0 = tkd_pkg::mk_event({1'b0, in_byte_value},
                                        in_byte_value + tkd_pkg::B_CASE_OFS, tkd_pkg::MF_CTRL);
              end else if (in_byte_value == tkd_pkg::B_DEL) begin
                ev0 = tkd_pkg::mk_event(tkd_pkg::K_BACKSPACE, 8'd0, tkd_pkg::MF_NONE);
              end else begin
                ev0 = tkd_pkg::mk_event({1'b0, in_byte_value}, in_byte_value,
                                        tkd_pkg::MF_NONE);
              end
            end
            tkd_pkg::PH_ESC: begin
              if (in_byte_value == tkd_pkg::B_LBRACK) begin
                phase_nxt = tkd_pkg::PH_CSI;
              end else if (in_byte_value == tkd_pkg::B_SS3) begin
                phase_nxt = tkd_pkg::PH_SS3;
              end else begin
                n_ev      = 2'd1;
                ev0       = tkd_pkg::mk_event({1'b0, in_byte_value}, in_byte_value,
                                              tkd_pkg::MF_ALT);
                phase_nxt = tkd_pkg::PH_IDLE;
              end
            end
            tkd_pkg::PH_CSI: begin
              if (in_byte_value inside {[8'h30:8'h39]}) begin
                num_nxt   = in_byte_value - tkd_pkg::B_ZERO;
                phase_nxt = tkd_pkg::PH_NUM;
              end else begin
                n_ev      = 2'd1;
                phase_nxt = tkd_pkg::PH_IDLE;
                if (in_byte_value == tkd_pkg::B_BACKTAB) begin
                  ev0 = tkd_pkg::mk_event(tkd_pkg::K_TAB, tkd_pkg::B_TAB, tkd_pkg::MF_SHIFT);
                end else if (tkd_pkg::letter_key(in_byte_value) != tkd_pkg::K_NONE) begin
                  ev0 = tkd_pkg::mk_event(tkd_pkg::letter_key(in_byte_value), 8'd0,
                                          tkd_pkg::MF_NONE);
                end else begin
                  ev0 = tkd_pkg::mk_event({1'b0, in_byte_value}, 8'd0, tkd_pkg::MF_NONE);
                end
              end
            end
            tkd_pkg::PH_NUM: begin
              if (in_byte_value inside {[8'h30:8'h39]}) begin
                num_nxt = (num_prod > 12'd255) ? 8'd255 : num_prod[7:0];
              end else if (in_byte_value == tkd_pkg::B_SEMI) begin
                phase_nxt = tkd_pkg::PH_MODWAIT;
              end else begin
                n_ev      = 2'd1;
                phase_nxt = tkd_pkg::PH_IDLE;
                ev0       = tkd_pkg::mk_event((in_byte_value == tkd_pkg::B_TILDE) ?
                                              tkd_pkg::tilde_key(num_r) : tkd_pkg::K_NONE,
                                              8'd0, tkd_pkg::MF_NONE);
              end
            end
            tkd_pkg::PH_MODWAIT: begin
              mods_nxt  = tkd_pkg::mod_flags(in_byte_value);
              phase_nxt = tkd_pkg::PH_MODKEY;
            end
            tkd_pkg::PH_MODKEY: begin
              n_ev      = 2'd1;
              phase_nxt = tkd_pkg::PH_IDLE;
              ev0       = tkd_pkg::mk_event(tkd_pkg::letter_key(in_byte_value), 8'd0, mods_r);
            end
            tkd_pkg::PH_SS3: begin
              n_ev      = 2'd1;
              phase_nxt = tkd_pkg::PH_IDLE;
              ev0       = tkd_pkg::mk_event(tkd_pkg::ss3_key(in_byte_value), 8'd0,
                                            tkd_pkg::MF_NONE);
            end
            default: begin
              phase_nxt = tkd_pkg::PH_IDLE;
            end
          endcase
        end
        tkd_pkg::REQ_TICK: begin
          if (phase_r != tkd_pkg::PH_IDLE) begin
            if (tick_next >= {1'b0, wait_lim}) begin
              wait_cnt_nxt = '0;
              if (phase_r == tkd_pkg::PH_MODWAIT) begin
                // wait afresh for the key byte, with no modifier
                mods_nxt  = tkd_pkg::MF_NONE;
                phase_nxt = tkd_pkg::PH_MODKEY;
              end else begin
                if (phase_r inside {[tkd_pkg::PH_ESC:tkd_pkg::PH_SS3]}) begin
                  n_ev = 2'd1;
                  ev0  = expire_event(phase_r, mods_r);
                end
                phase_nxt = tkd_pkg::PH_IDLE;
              end
            end else begin
              wait_cnt_nxt = tick_next[15:0];
            end
          end
        end
        tkd_pkg::REQ_EOS: begin
          // flush a pending sequence, then quit
          phase_nxt    = tkd_pkg::PH_IDLE;
          wait_cnt_nxt = '0;
          if (phase_r inside {[tkd_pkg::PH_ESC:tkd_pkg::PH_SS3]}) begin
            n_ev = 2'd2;
            ev0  = (phase_r == tkd_pkg::PH_MODWAIT) ?
                   tkd_pkg::mk_event(tkd_pkg::K_NONE, 8'd0, tkd_pkg::MF_NONE) :
                   expire_event(phase_r, mods_r);
            ev1  = tkd_pkg::quit_event();
          end else begin
            n_ev = 2'd1;
            ev0  = tkd_pkg::quit_event();
          end
        end
        default: ;
      endcase
      // leaving to idle clears the sequence state
      if (phase_nxt == tkd_pkg::PH_IDLE) begin
        num_nxt      = '0;
        mods_nxt     = tkd_pkg::MF_NONE;
        wait_cnt_nxt = '0;
      end
      // mark the final event of this beat
      if (n_ev == 2'd1) ev0.last = 1'b1;
      if (n_ev == 2'd2) ev1.last = 1'b1;
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= tkd_pkg::PH_IDLE;
      num_r      <= '0;
      mods_r     <= tkd_pkg::MF_NONE;
      wait_cnt_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      num_r      <= num_nxt;
      mods_r     <= mods_nxt;
      wait_cnt_r <= wait_cnt_nxt;
    end
  end

  // Queue occupancy
  always_comb begin
    count_nxt = count_r + tkd_pkg::CNT_W'(n_ev) - tkd_pkg::CNT_W'(out_acc);
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + tkd_pkg::PTR_W'(n_ev);
      rd_ptr_r <= rd_ptr_r + tkd_pkg::PTR_W'(out_acc);
      count_r  <= count_nxt;
    end
  end

  // Store up to two events per beat
  always_ff @(posedge clk) begin
    if (n_ev != 2'd0) fifo_r[wr_ptr_r] <= ev0;
    if (n_ev == 2'd2) fifo_r[wr_ptr_r + tkd_pkg::PTR_W'(1)] <= ev1;
  end

  // Present the queue head
  assign head            = fifo_r[rd_ptr_r];
  assign out_key_code    = head.key;
  assign out_char_value  = head.ch;
  assign out_ctrl_mod    = head.mods[0];
  assign out_shift_mod   = head.mods[1];
  assign out_alt_mod     = head.mods[2];
  assign out_quit_event  = head.quit;
  assign out_last_of_run = head.last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tkd_pkg::CNT_W'(tkd_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == tkd_pkg::PH_IDLE) |-> (num_r == '0 && mods_r == '0 && wait_cnt_r == '0))
    else $error("idle phase with leftover sequence state");

  a_eos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type == tkd_pkg::REQ_EOS) |=>
      (phase_r == tkd_pkg::PH_IDLE && count_r != '0))
    else $error("end of stream did not flush the parser");

  a_wait_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != tkd_pkg::PH_IDLE && $past(in_valid && in_ready &&
      in_req_type == tkd_pkg::REQ_TICK) && $past(phase_r) == phase_r) |->
      ({1'b0, wait_cnt_r} < {1'b0, wait_lim} || wait_cnt_r == '0))
    else $error("wait counter passed its limit");
`endif

endmodule

`default_nettype wire
